[rtl/xsfb_pkg.sv]
package xsfb_pkg;

   localparam int RowBits   = 64;
   localparam int ByteBits  = 8;
   localparam int ReqBits   = 24;
   localparam int RspBits   = 16;
   localparam int QueueCntW = 2;

   // Row bit that holds the rightmost pixel of a byte placed at column zero.
   localparam logic [5:0] ByteTailCol = 6'(RowBits - ByteBits);

   typedef enum logic [1:0] {
      CMD_DRAW  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_DRAW,
      OP_READ,
      OP_CLEAR
   } op_kind_type;

   typedef struct packed {
      op_kind_type  kind;
      logic [5:0]   column;
      logic [4:0]   row;
      logic [7:0]   sprite;
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } back_state_type;

endpackage

[rtl/xsfb_front.sv]
module xsfb_front #(
   parameter int ROW_COUNT = 32
) (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [xsfb_pkg::ReqBits-1:0]      req_tdata,
   input  logic                              q_full,
   output logic                              q_push,
   output xsfb_pkg::op_type                  q_data
);
   import xsfb_pkg::*;

   localparam logic [6:0] RowLimit = 7'(ROW_COUNT);

   logic [1:0] cmd;
   logic       in_range;

   assign cmd      = req_tdata[1:0];
   assign in_range = {2'b00, req_tdata[12:8]} < RowLimit;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_data.column = req_tdata[7:2];
      q_data.row    = req_tdata[12:8];
      q_data.sprite = req_tdata[20:13];
      // Rows past the store and the unused command code become no-ops that
      // still yield an all-zero result.
      unique case (cmd)
         CMD_DRAW:  q_data.kind = in_range ? OP_DRAW : OP_NOP;
         CMD_READ:  q_data.kind = in_range ? OP_READ : OP_NOP;
         CMD_CLEAR: q_data.kind = OP_CLEAR;
         default:   q_data.kind = OP_NOP;
      endcase
   end

endmodule

[rtl/xsfb_queue.sv]
module xsfb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  xsfb_pkg::op_type push_data,
   output logic             full,
   input  logic             pop,
   output xsfb_pkg::op_type pop_data,
   output logic             empty
);
   import xsfb_pkg::*;

   op_type                entries_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/xsfb_back.sv]
module xsfb_back #(
   parameter int ROW_COUNT = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  xsfb_pkg::op_type                  q_data,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [xsfb_pkg::RspBits-1:0]      rsp_tdata
);
   import xsfb_pkg::*;

   localparam int RowIdxW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

   back_state_type          state_ff, state_in;
   op_type                  op_ff;
   logic [RowBits-1:0]      pixel_rows_ff [ROW_COUNT];
   logic [RowBits-1:0]      row_q_ff;
   logic                    row_valid_ff;
   logic [ROW_COUNT-1:0]    valid_ff, valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RspBits-1:0]      rsp_data_ff;

   logic                    rd_en, done, wr_en, out_free;
   logic [RowIdxW+4:0]      rd_row_wide, op_row_wide;
   logic [RowIdxW-1:0]      rd_idx, wr_idx;
   logic [RowBits-1:0]      cur_row, new_row;
   logic [2*RowBits-1:0]    cur_dbl, spr_dbl;
   logic [RowBits+ByteBits-1:0] cur_ext;
   logic [5:0]              sh;
   logic [6:0]              rd_sh;
   logic [ByteBits-1:0]     under, rd_byte, read_byte, collision_bits;

   assign rd_row_wide = {{RowIdxW{1'b0}}, q_data.row};
   assign op_row_wide = {{RowIdxW{1'b0}}, op_ff.row};
   assign rd_idx      = rd_row_wide[RowIdxW-1:0];
   assign wr_idx      = op_row_wide[RowIdxW-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      done     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               rd_en    = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Bit 63 of a row is column 0. Shifting by 56 minus the column lines the
   // addressed byte up with bits 7..0, wrapping around the row for draws.
   assign cur_row = row_valid_ff ? row_q_ff : '0;
   assign sh      = ByteTailCol - op_ff.column;
   assign cur_dbl = {cur_row, cur_row};
   assign under   = cur_dbl[sh +: ByteBits];
   assign spr_dbl = {{(RowBits-ByteBits){1'b0}}, op_ff.sprite,
                     {(RowBits-ByteBits){1'b0}}, op_ff.sprite} << sh;
   assign new_row = cur_row ^ spr_dbl[2*RowBits-1:RowBits];

   // Reads do not wrap: pad the row with zeros past its right edge.
   assign cur_ext = {cur_row, {ByteBits{1'b0}}};
   assign rd_sh   = 7'(RowBits) - {1'b0, op_ff.column};
   assign rd_byte = cur_ext[rd_sh +: ByteBits];

   assign read_byte      = (op_ff.kind == OP_READ) ? rd_byte : '0;
   assign collision_bits = (op_ff.kind == OP_DRAW) ? (under & op_ff.sprite) : '0;

   assign wr_en = done && (op_ff.kind == OP_DRAW);

   always_comb begin
      valid_in = valid_ff;
      if (done && op_ff.kind == OP_CLEAR) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_rows_ff[wr_idx] <= new_row;
      end
      if (rd_en) begin
         row_q_ff     <= pixel_rows_ff[rd_idx];
         row_valid_ff <= valid_ff[rd_idx];
         op_ff        <= q_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= {collision_bits, read_byte};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_pop_to_exec: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_EXEC))
      else $error("popped item did not reach execute");

   a_no_read_bits: assert property (@(posedge clock) disable iff (reset)
      (done && op_ff.kind != OP_READ) |=> (rsp_tdata[ByteBits-1:0] == '0))
      else $error("read byte set on a non-read result");

   a_no_collision: assert property (@(posedge clock) disable iff (reset)
      (done && op_ff.kind != OP_DRAW) |=> (rsp_tdata[RspBits-1:ByteBits] == '0))
      else $error("collision bits set on a non-draw result");

   a_clear_blanks: assert property (@(posedge clock) disable iff (reset)
      (done && op_ff.kind == OP_CLEAR) |=> (valid_ff == '0))
      else $error("clear left rows marked written");
`endif

endmodule

[rtl/xor_sprite_framebuffer_unit.sv]
// XOR sprite framebuffer: a store of ROW_COUNT rows of 64 one-bit pixels.
// Commands arrive on the req_ channel, one item per command; every item
// yields exactly one item on the rsp_ channel, in order.
//   Draw XORs an 8-pixel byte into a row, wrapping past column 63, and
//   returns the pixels it turned off. Read returns 8 pixels at a column,
//   with columns past 63 reading as zero. Clear blanks the whole store.
//   Rows past ROW_COUNT and the unused command code give an all-zero result.
// A classifier feeds a two-entry command queue; the execute side registers
// the addressed row, then writes it back with the result once the output
// register is free, and takes no new item until that write-back is done.
// When idle, an accepted item passes the queue entry, the row register and
// the output register, in that order, before rsp_tvalid rises.
// Clear takes the same path: per-row written flags are dropped at once.
// Reset blanks the screen immediately; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register, the
// execute side reads at most one more row and then waits, and req_tready
// falls once the queue is full.
module xor_sprite_framebuffer_unit #(
   parameter int ROW_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // cmd[1:0], column[7:2], row[12:8], sprite_byte[20:13]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // read_byte[7:0], collision_bits[15:8]
);
   import xsfb_pkg::*;

   op_type front_op;
   op_type queue_op;
   logic   q_push, q_full, q_pop, q_empty;

   xsfb_front #(.ROW_COUNT(ROW_COUNT)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (front_op)
   );

   xsfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_op),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (queue_op),
      .empty     (q_empty)
   );

   xsfb_back #(.ROW_COUNT(ROW_COUNT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (queue_op),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[test/xor_sprite_framebuffer_unit_tb.sv]
module xor_sprite_framebuffer_unit_tb;
   import xsfb_pkg::*;

   localparam int RowCount = 32;
   localparam int CycleLimit = 200000;
   localparam int RandomItems = 1300;
   localparam int LongHoldCycles = 300;
   localparam int DrainCycles = 20;
   localparam logic [1:0] CmdUnused = 2'd3;

   // Packed as on req_tdata: cmd in the lowest bits, zero fill at the top.
   typedef struct packed {
      logic [2:0] fill;
      logic [7:0] sprite;
      logic [4:0] row;
      logic [5:0] column;
      logic [1:0] cmd;
   } screen_cmd_type;

   // Packed as on rsp_tdata: read_byte in the lowest bits.
   typedef struct packed {
      logic [7:0] collision_bits;
      logic [7:0] read_byte;
   } pixel_result_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] column;
      logic [4:0] row;
      logic [7:0] sprite;
      logic       has_fixed;
      logic [7:0] read_byte;
      logic [7:0] collision_bits;
   } directed_row_type;

   localparam int NumDirected = 22;

   // Fixed results are given only where they follow directly from the command
   // or a blank or freshly written screen; the rest come from the screen model below.
   directed_row_type directed_rows [NumDirected] = '{
      '{CMD_READ,  6'd0,  5'd0,  8'h00, 1'b1, 8'h00, 8'h00},
      '{CMD_DRAW,  6'd0,  5'd0,  8'hFF, 1'b1, 8'h00, 8'h00},
      '{CMD_READ,  6'd0,  5'd0,  8'h00, 1'b1, 8'hFF, 8'h00},
      '{CMD_DRAW,  6'd0,  5'd0,  8'hFF, 1'b1, 8'h00, 8'hFF},
      '{CMD_DRAW,  6'd63, 5'd31, 8'hA5, 1'b0, 8'h00, 8'h00},
      '{CMD_READ,  6'd63, 5'd31, 8'h00, 1'b0, 8'h00, 8'h00},
      '{CMD_READ,  6'd0,  5'd31, 8'h00, 1'b0, 8'h00, 8'h00},
      '{CMD_DRAW,  6'd56, 5'd31, 8'hFF, 1'b0, 8'h00, 8'h00},
      '{CMD_READ,  6'd56, 5'd31, 8'h00, 1'b0, 8'h00, 8'h00},
      '{CMD_DRAW,  6'd60, 5'd5,  8'h81, 1'b0, 8'h00, 8'h00},
      '{CMD_READ,  6'd57, 5'd5,  8'h00, 1'b0, 8'h00, 8'h00},
      '{CMD_DRAW,  6'd60, 5'd5,  8'hFF, 1'b0, 8'h00, 8'h00},
      '{CmdUnused, 6'd60, 5'd5,  8'hFF, 1'b1, 8'h00, 8'h00},
      '{CMD_READ,  6'd59, 5'd5,  8'h00, 1'b0, 8'h00, 8'h00},
      '{CMD_CLEAR, 6'd63, 5'd31, 8'hFF, 1'b1, 8'h00, 8'h00},
      '{CMD_READ,  6'd60, 5'd5,  8'h00, 1'b1, 8'h00, 8'h00},
      '{CMD_READ,  6'd0,  5'd31, 8'h00, 1'b1, 8'h00, 8'h00},
      '{CMD_DRAW,  6'd33, 5'd17, 8'h00, 1'b1, 8'h00, 8'h00},
      '{CMD_DRAW,  6'd63, 5'd31, 8'h80, 1'b1, 8'h00, 8'h00},
      '{CMD_READ,  6'd63, 5'd31, 8'h00, 1'b1, 8'h80, 8'h00},
      '{CMD_READ,  6'd62, 5'd31, 8'h00, 1'b0, 8'h00, 8'h00},
      '{CMD_READ,  6'd0,  5'd31, 8'hFF, 1'b0, 8'h00, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   logic [63:0]      screen [RowCount];
   pixel_result_type pending_results [$];
   screen_cmd_type   last_draw;

   int error_count = 0;
   int cycle_count = 0;
   int input_stall_cycles = 0;
   int burst_left = 0;
   int draw_count = 0;
   int read_count = 0;
   int clear_count = 0;
   int unused_count = 0;
   int collision_count = 0;
   int long_holds_done = 0;
   bit long_hold_req = 1'b0;

   xor_sprite_framebuffer_unit #(
      .ROW_COUNT(RowCount)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Row bit 63 is column 0, so the bit for a column is its complement.
   function automatic pixel_result_type apply_command(screen_cmd_type c);
      pixel_result_type res;
      logic [63:0]      line;
      logic [5:0]       col_at;
      int               pos;
      int               i;
      res = '0;
      line = screen[c.row];
      case (c.cmd)
         CMD_DRAW: begin
            draw_count++;
            if (c.row < RowCount) begin
               for (i = 0; i < 8; i++) begin
                  col_at = c.column + 6'(i);
                  if (c.sprite[7 - i]) begin
                     res.collision_bits[7 - i] = line[~col_at];
                     line[~col_at] = ~line[~col_at];
                  end
               end
               screen[c.row] = line;
            end
            if (res.collision_bits != '0) collision_count++;
         end
         CMD_READ: begin
            read_count++;
            if (c.row < RowCount) begin
               for (i = 0; i < 8; i++) begin
                  pos = int'(c.column) + i;
                  if (pos <= 63) res.read_byte[7 - i] = line[63 - pos];
               end
            end
         end
         CMD_CLEAR: begin
            clear_count++;
            for (i = 0; i < RowCount; i++) screen[i] = '0;
         end
         default: unused_count++;
      endcase
      return res;
   endfunction

   // Mostly draws and reads on a few rows so that collisions are common;
   // a fifth of the draws repeat the previous one to erase it again.
   function automatic screen_cmd_type random_command();
      screen_cmd_type c;
      int             roll;
      c = '0;
      roll = $urandom_range(0, 99);
      c.row = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
      c.column = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(56, 63))
                                             : 6'($urandom_range(0, 63));
      c.sprite = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
      if (roll < 2) begin
         c.cmd = CMD_CLEAR;
      end else if (roll < 5) begin
         c.cmd = CmdUnused;
      end else if (roll < 55) begin
         c.cmd = CMD_DRAW;
         if ($urandom_range(0, 4) == 0 && last_draw.cmd == CMD_DRAW) c = last_draw;
         last_draw = c;
      end else begin
         c.cmd = CMD_READ;
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] expected_val, logic [7:0] got_val);
      $display("mismatch at cycle %0d: %s expected %02h got %02h",
               cycle_count, what, expected_val, got_val);
      error_count++;
   endtask

   task automatic offer_item(screen_cmd_type c);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= c;
      do @(posedge clock); while (!req_tready);
   endtask

   // Bursts of random length; valid only drops between bursts.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_tvalid && !req_tready && !reset) input_stall_cycles <= input_stall_cycles + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      pixel_result_type got;
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item, rsp_tdata low byte", 8'h00, got.read_byte);
         end else begin
            want = pending_results.pop_front();
            if (got.read_byte !== want.read_byte)
               report_mismatch("read_byte", want.read_byte, got.read_byte);
            if (got.collision_bits !== want.collision_bits)
               report_mismatch("collision_bits", want.collision_bits, got.collision_bits);
         end
      end
   end

   // Receiver: stretches of different stall patterns, plus one long hold-off
   // that lets the block fill up and push back on the sender.
   initial begin
      int mode;
      int len;
      int i;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LongHoldCycles) @(negedge clock);
            long_hold_req = 1'b0;
            long_holds_done++;
         end
         mode = $urandom_range(0, 3);
         len = $urandom_range(20, 120);
         for (i = 0; i < len; i++) begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (i % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin
      screen_cmd_type   c;
      pixel_result_type predicted;
      int               n;
      for (n = 0; n < RowCount; n++) screen[n] = '0;
      last_draw = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < NumDirected; n++) begin
         c = '0;
         c.cmd = directed_rows[n].cmd;
         c.column = directed_rows[n].column;
         c.row = directed_rows[n].row;
         c.sprite = directed_rows[n].sprite;
         offer_item(c);
         predicted = apply_command(c);
         if (directed_rows[n].has_fixed) begin
            predicted.read_byte = directed_rows[n].read_byte;
            predicted.collision_bits = directed_rows[n].collision_bits;
         end
         pending_results.push_back(predicted);
         pace_sender();
      end

      long_hold_req = 1'b1;
      for (n = 0; n < RandomItems; n++) begin
         c = random_command();
         offer_item(c);
         pending_results.push_back(apply_command(c));
         pace_sender();
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_results.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d draws (%0d colliding), %0d reads, %0d clears, %0d unused codes",
               draw_count, collision_count, read_count, clear_count, unused_count);
      $display("input held off for %0d cycles, %0d long receiver hold-offs",
               input_stall_cycles, long_holds_done);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/xsfb_pkg.sv
rtl/xsfb_front.sv
rtl/xsfb_queue.sv
rtl/xsfb_back.sv
rtl/xor_sprite_framebuffer_unit.sv
test/xor_sprite_framebuffer_unit_tb.sv
